### rtl/ascon_pkg.sv
// Package: shared types, constants and the Ascon round function.
package ascon_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_AD    = 2'd1;
  localparam logic [1:0] OP_MSG   = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_TAG   = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic [63:0] INIT_VECTOR = 64'h00001000808c0001;
  localparam logic [63:0] DOMAIN_BIT  = 64'h8000000000000000;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NOAD   = 2'd1,
    PH_ADOPEN = 2'd2,
    PH_MSG    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERM,
    ST_STEP,
    ST_OUT_DATA,
    ST_OUT_TAG,
    ST_OUT_CHECK
  } eng_state_t;

  // queued request between front and back
  typedef struct packed {
    logic [1:0]  opcode;
    logic        decrypt_mode;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [4:0]  n;
    logic        last;
  } req_t;

  typedef logic [63:0] lanes_t [5];

  function automatic logic [63:0] ror64(input logic [63:0] x, input int s);
    ror64 = (x >> s) | (x << (64 - s));
  endfunction

  function automatic logic [319:0] ascon_round(input logic [319:0] st,
                                               input logic [3:0] r);
    logic [63:0] a, b, c, d, e, na, nb, nc, nd, ne;
    a = st[63:0]; b = st[127:64]; c = st[191:128]; d = st[255:192]; e = st[319:256];
    c = c ^ {56'd0, 8'hf0 - {4'd0, r} * 8'h0f};
    a = a ^ e; e = e ^ d; c = c ^ b;
    na = ~a & b; nb = ~b & c; nc = ~c & d; nd = ~d & e; ne = ~e & a;
    a = a ^ nb; b = b ^ nc; c = c ^ nd; d = d ^ ne; e = e ^ na;
    b = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
    a = a ^ ror64(a, 19) ^ ror64(a, 28);
    b = b ^ ror64(b, 61) ^ ror64(b, 39);
    c = c ^ ror64(c, 1) ^ ror64(c, 6);
    d = d ^ ror64(d, 10) ^ ror64(d, 17);
    e = e ^ ror64(e, 7) ^ ror64(e, 41);
    ascon_round = {e, d, c, b, a};
  endfunction

  function automatic logic [63:0] mask_low(input logic [4:0] n);
    if (n >= 5'd8) mask_low = '1;
    else mask_low = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
  endfunction

  function automatic logic [63:0] mask_high(input logic [4:0] n);
    if (n <= 5'd8) mask_high = '0;
    else if (n >= 5'd16) mask_high = '1;
    else mask_high = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
  endfunction

  function automatic logic [127:0] pad_bits(input logic [4:0] n);
    pad_bits = '0;
    if (n < 5'd16) pad_bits = 128'd1 << {n[3:0], 3'b000};
  endfunction

endpackage

### rtl/ascon_front.sv
// Input front: saturates byte count and queues requests in a two-entry FIFO.
module ascon_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_opcode,
  input  logic                 in_decrypt_mode,
  input  logic [63:0]          in_w0,
  input  logic [63:0]          in_w1,
  input  logic [4:0]           in_n,
  input  logic                 in_last,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ascon_pkg::req_t      q_req
);
  import ascon_pkg::*;

  req_t      fifo_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t      req;
  logic      push, pop;

  always_comb begin
    req.opcode       = in_opcode;
    req.decrypt_mode = in_decrypt_mode;
    req.w0           = in_w0;
    req.w1           = in_w1;
    req.last         = in_last;
    // non-last blocks are full; saturate above sixteen
    if (!in_last || in_n > 5'd16) req.n = 5'd16;
    else req.n = in_n;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_req     = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("fifo count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop from empty fifo");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full fifo");

endmodule

### rtl/ascon_back.sv
// Back end: Ascon sequencer with one permutation round per cycle.
module ascon_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [63:0]          key_low,
  input  logic [63:0]          key_high,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  ascon_pkg::req_t      q_req,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [1:0]           out_kind,
  output logic [63:0]          out_w0,
  output logic [63:0]          out_w1,
  output logic [4:0]           out_n,
  output logic                 out_ok,
  output logic                 out_last
);
  import ascon_pkg::*;

  // step codes after each permutation
  localparam logic [2:0] AF_INIT   = 3'd0; // start: add key
  localparam logic [2:0] AF_AD     = 3'd1; // AD block done
  localparam logic [2:0] AF_ADPAD  = 3'd2; // full last AD: pad block next
  localparam logic [2:0] AF_ENTER  = 3'd3; // lone pad before message
  localparam logic [2:0] AF_MSG    = 3'd4; // non-last message done
  localparam logic [2:0] AF_MFULL  = 3'd5; // full last message: finalize
  localparam logic [2:0] AF_FINAL  = 3'd6; // tag ready

  eng_state_t  st_r, st_nxt;
  logic [319:0] s_r, s_nxt;
  phase_t      ph_r, ph_nxt;
  logic        dir_r, dir_nxt;
  logic [63:0] tag0_r, tag0_nxt, tag1_r, tag1_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic [2:0]  af_r, af_nxt;
  req_t        cur_r, cur_nxt;
  logic [63:0] o0_r, o0_nxt, o1_r, o1_nxt;
  logic        ok_r, ok_nxt;

  logic [63:0] m0, m1;
  logic [127:0] pad;

  always_comb begin
    m0  = mask_low(cur_r.n);
    m1  = mask_high(cur_r.n);
    pad = pad_bits(cur_r.n);
  end

  // next-state and datapath
  always_comb begin
    st_nxt = st_r; s_nxt = s_r; ph_nxt = ph_r; dir_nxt = dir_r;
    tag0_nxt = tag0_r; tag1_nxt = tag1_r; rnd_nxt = rnd_r; af_nxt = af_r;
    cur_nxt = cur_r; o0_nxt = o0_r; o1_nxt = o1_r; ok_nxt = ok_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_req;
          st_nxt  = ST_STEP;
          af_nxt  = AF_ENTER;
          case (q_req.opcode)
            OP_START: begin
              s_nxt   = {q_req.w1, q_req.w0, key_high, key_low, INIT_VECTOR};
              dir_nxt = q_req.decrypt_mode;
              rnd_nxt = 4'd0; af_nxt = AF_INIT; st_nxt = ST_PERM;
            end
            OP_AD: begin
              if (ph_r != PH_NOAD && ph_r != PH_ADOPEN) st_nxt = ST_IDLE;
            end
            OP_CHECK: begin
              if (ph_r != PH_IDLE) st_nxt = ST_IDLE;
              else begin
                ok_nxt = (q_req.w0 == tag0_r) && (q_req.w1 == tag1_r);
                st_nxt = ST_OUT_CHECK;
              end
            end
            OP_MSG: begin
              if (ph_r == PH_IDLE) st_nxt = ST_IDLE;
              else if (ph_r == PH_ADOPEN) begin
                s_nxt[0] = s_r[0] ^ 1'b1;
                rnd_nxt = 4'd4; af_nxt = AF_ENTER; st_nxt = ST_PERM;
              end else if (ph_r == PH_NOAD) begin
                s_nxt[319:256] = s_r[319:256] ^ DOMAIN_BIT;
                ph_nxt = PH_MSG;
              end
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PERM: begin
        s_nxt   = ascon_round(s_r, rnd_r);
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd11) begin
          case (af_r)
            AF_INIT: begin
              s_nxt[255:192] = s_nxt[255:192] ^ key_low;
              s_nxt[319:256] = s_nxt[319:256] ^ key_high;
              ph_nxt = PH_NOAD; st_nxt = ST_IDLE;
            end
            AF_AD: begin
              if (cur_r.last) begin
                s_nxt[319:256] = s_nxt[319:256] ^ DOMAIN_BIT;
                ph_nxt = PH_MSG;
              end else ph_nxt = PH_ADOPEN;
              st_nxt = ST_IDLE;
            end
            AF_ADPAD: begin
              s_nxt[0] = s_nxt[0] ^ 1'b1;
              rnd_nxt = 4'd4; af_nxt = AF_AD; st_nxt = ST_PERM;
            end
            AF_ENTER: begin
              s_nxt[319:256] = s_nxt[319:256] ^ DOMAIN_BIT;
              ph_nxt = PH_MSG; st_nxt = ST_STEP;
            end
            AF_MSG: st_nxt = ST_OUT_DATA;
            AF_MFULL: begin
              s_nxt[0] = s_nxt[0] ^ 1'b1;
              s_nxt[191:128] = s_nxt[191:128] ^ key_low;
              s_nxt[255:192] = s_nxt[255:192] ^ key_high;
              rnd_nxt = 4'd0; af_nxt = AF_FINAL; st_nxt = ST_PERM;
            end
            default: begin
              tag0_nxt = s_nxt[255:192] ^ key_low;
              tag1_nxt = s_nxt[319:256] ^ key_high;
              ph_nxt = PH_IDLE; st_nxt = ST_OUT_DATA;
            end
          endcase
        end
      end
      ST_STEP: begin
        // absorb AD or process a message block on the current state
        if (cur_r.opcode == OP_AD) begin
          if (cur_r.last && cur_r.n == 5'd0 && ph_r == PH_NOAD) begin
            s_nxt[319:256] = s_r[319:256] ^ DOMAIN_BIT;
            ph_nxt = PH_MSG; st_nxt = ST_IDLE;
          end else begin
            s_nxt[63:0]   = s_r[63:0] ^ (cur_r.w0 & m0);
            s_nxt[127:64] = s_r[127:64] ^ (cur_r.w1 & m1);
            if (cur_r.n != 5'd16) s_nxt[127:0] = s_nxt[127:0] ^ pad;
            rnd_nxt = 4'd4; st_nxt = ST_PERM;
            af_nxt = (cur_r.n == 5'd16 && cur_r.last) ? AF_ADPAD : AF_AD;
          end
        end else begin
          if (dir_r) begin
            o0_nxt = (s_r[63:0] ^ cur_r.w0) & m0;
            o1_nxt = (s_r[127:64] ^ cur_r.w1) & m1;
            s_nxt[63:0]   = (cur_r.w0 & m0) | (s_r[63:0] & ~m0);
            s_nxt[127:64] = (cur_r.w1 & m1) | (s_r[127:64] & ~m1);
          end else begin
            s_nxt[63:0]   = s_r[63:0] ^ (cur_r.w0 & m0);
            s_nxt[127:64] = s_r[127:64] ^ (cur_r.w1 & m1);
            o0_nxt = s_nxt[63:0] & m0;
            o1_nxt = s_nxt[127:64] & m1;
          end
          st_nxt = ST_PERM;
          if (!cur_r.last) begin
            rnd_nxt = 4'd4; af_nxt = AF_MSG;
          end else if (cur_r.n == 5'd16) begin
            rnd_nxt = 4'd4; af_nxt = AF_MFULL;
          end else begin
            s_nxt[127:0]   = s_nxt[127:0] ^ pad;
            s_nxt[191:128] = s_nxt[191:128] ^ key_low;
            s_nxt[255:192] = s_nxt[255:192] ^ key_high;
            rnd_nxt = 4'd0; af_nxt = AF_FINAL;
          end
        end
      end
      ST_OUT_DATA: begin
        if (out_tready) st_nxt = cur_r.last ? ST_OUT_TAG : ST_IDLE;
      end
      ST_OUT_TAG, ST_OUT_CHECK: begin
        if (out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready = (st_r == ST_IDLE);
    out_tvalid = 1'b0; out_kind = KIND_DATA; out_w0 = '0; out_w1 = '0;
    out_n = '0; out_ok = 1'b0; out_last = 1'b1;
    case (st_r)
      ST_OUT_DATA: begin
        out_tvalid = 1'b1; out_w0 = o0_r; out_w1 = o1_r;
        out_n = cur_r.n; out_last = !cur_r.last;
      end
      ST_OUT_TAG: begin
        out_tvalid = 1'b1; out_kind = KIND_TAG; out_w0 = tag0_r; out_w1 = tag1_r;
      end
      ST_OUT_CHECK: begin
        out_tvalid = 1'b1; out_kind = KIND_CHECK; out_ok = ok_r;
      end
      default: out_tvalid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; rnd_r <= rnd_nxt; af_r <= af_nxt; cur_r <= cur_nxt;
    o0_r <= o0_nxt; o1_r <= o1_nxt; ok_r <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ph_r <= PH_IDLE; dir_r <= 1'b0;
      tag0_r <= '0; tag1_r <= '0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; dir_r <= dir_nxt;
      tag0_r <= tag0_nxt; tag1_r <= tag1_nxt;
    end
  end

  a_tag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT_DATA && out_tready && cur_r.last) |=> st_r == ST_OUT_TAG)
    else $error("tag did not follow last data");
  a_idle_after_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT_TAG) |-> ph_r == PH_IDLE) else $error("tag out of idle");
  a_perm_key: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PERM && rnd_r == 4'd11 && af_r == AF_INIT) |=> ph_r == PH_NOAD)
    else $error("init did not open session");

endmodule

### rtl/ascon_aead128_engine_unit.sv
// Ascon-AEAD128 engine top level: config registers, front queue and back sequencer.
// Usage: write key_low (index 0) and key_high (index 1) on the cfg channel while idle.
// Requests enter on in_*: tdata = {byte_count, in_word_high, in_word_low},
// tuser = {decrypt_mode, opcode}, tlast = last_block. Results leave on out_*:
// tdata = {out_byte_count, out_word_high, out_word_low}, tuser = {auth_ok, result_kind},
// tlast = last_result.
// Steps: start runs the initialization permutation and adds the key; an AD block is
// absorbed and permuted (plus a pad block for a full last block); a message block is
// permuted before its data result (after first closing open AD). A partial last
// message block is finalized before data and tag, a full one permuted first.
// A tag check answers in the next cycle. The shared round unit (one round per cycle)
// holds the back end least for an ignored request and longest for a full last message
// that first closes open AD; a two-entry queue takes new requests while one is processed.
// Reset clears phase, direction, saved tag, key and queue; no clearing pass is needed.
// When out_tready is low the result is held and the sequencer stalls; the queue then
// fills and in_tready drops.
module ascon_aead128_engine_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [135:0]  in_tdata,   // in_word_low, in_word_high, byte_count, pad
  input  logic [2:0]    in_tuser,   // opcode, decrypt_mode
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [135:0]  out_tdata,  // out_word_low, out_word_high, out_byte_count, pad
  output logic [2:0]    out_tuser,  // result_kind, auth_ok
  output logic          out_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_data
);
  import ascon_pkg::*;

  logic [63:0] key_low_r, key_high_r;
  logic        q_valid, q_ready;
  req_t        q_req;
  logic [1:0]  o_kind;
  logic [63:0] o_w0, o_w1;
  logic [4:0]  o_n;
  logic        o_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= '0; key_high_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_KEY_LOW) key_low_r <= cfg_data;
      else key_high_r <= cfg_data;
    end
  end

  ascon_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_opcode(in_tuser[1:0]), .in_decrypt_mode(in_tuser[2]),
    .in_w0(in_tdata[63:0]), .in_w1(in_tdata[127:64]), .in_n(in_tdata[132:128]),
    .in_last(in_tlast), .q_valid, .q_ready, .q_req
  );

  ascon_back u_back (
    .clk, .rst_n, .key_low(key_low_r), .key_high(key_high_r),
    .q_valid, .q_ready, .q_req, .out_tvalid, .out_tready,
    .out_kind(o_kind), .out_w0(o_w0), .out_w1(o_w1), .out_n(o_n),
    .out_ok(o_ok), .out_last(out_tlast)
  );

  assign out_tdata = {3'd0, o_n, o_w1, o_w0};
  assign out_tuser = {o_ok, o_kind};

endmodule
